// ----- rtl/crcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfc_pkg: shared definitions for the crc frame checker
// Frame layout sizes, crc-16 constants and status codes.
// ----------------------------------------------------------------------------
package crcfc_pkg;

    // frame layout
    localparam int          HDR_BYTES      = 6;
    localparam int          OVERHEAD_BYTES = 8;
    localparam int          COUNT_W        = 17;
    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;

    // crc-16 ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // register reset
    localparam logic [7:0]  VERSION_RESET = 8'd1;

    // status codes
    localparam logic [1:0]  STATUS_OK      = 2'd0;
    localparam logic [1:0]  STATUS_SHORT   = 2'd1;
    localparam logic [1:0]  STATUS_VERSION = 2'd2;
    localparam logic [1:0]  STATUS_CRC     = 2'd3;

    // output kinds
    localparam logic        KIND_PAYLOAD = 1'b0;
    localparam logic        KIND_STATUS  = 1'b1;

endpackage

// ----- rtl/crcfc_crc_byte.sv -----
// ----------------------------------------------------------------------------
// crcfc_crc_byte: one-byte crc-16 update
// Folds one byte into a crc-16 (poly 0x1021, msb first), eight bit steps.
// ----------------------------------------------------------------------------
module crcfc_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    // eight shift-and-xor steps on a 16-bit value
    always_comb begin
        logic [15:0] v;
        v = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((v & crcfc_pkg::CRC_MSB) != 16'h0000) begin
                v = {v[14:0], 1'b0} ^ crcfc_pkg::CRC_POLY;
            end else begin
                v = {v[14:0], 1'b0};
            end
        end
        o_crc = v;
    end

endmodule

// ----- rtl/crc_frame_checker.sv -----
// ----------------------------------------------------------------------------
// crc_frame_checker: byte-stream frame checker with crc-16
// Timing: a result is registered and shown in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle while the output is not stalled; the crc byte update and header capture
// fit between the frame state registers and the output register.
// Reset: synchronous active-low; clears frame state, output valid and sets
// the expected version to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module crc_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: expected version
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] payload_offset,
                                        // [25:24] frame_status, [33:26] frame_type,
                                        // [49:34] frame_seq, [65:50] payload_len, rest 0
    output logic        m_axis_tuser    // out_kind
);

    localparam int CW = crcfc_pkg::COUNT_W;

    // configuration and frame state
    logic [7:0]    r_exp_version;
    logic [15:0]   r_crc;
    logic [CW-1:0] r_count;
    logic [7:0]    r_version;
    logic [7:0]    r_type;
    logic [15:0]   r_seq;
    logic [15:0]   r_length;
    logic [15:0]   r_crc_rx;

    logic [15:0]   n_crc;
    logic [CW-1:0] n_count;
    logic [7:0]    n_version;
    logic [7:0]    n_type;
    logic [15:0]   n_seq;
    logic [15:0]   n_length;
    logic [15:0]   n_crc_rx;

    // output register
    logic          r_out_valid;
    logic          r_out_kind;
    logic [71:0]   r_out_data;

    logic          w_in_acc;
    logic [15:0]   w_crc_fed;
    logic [CW-1:0] w_crc_pos;
    logic          w_forward;
    logic [1:0]    w_status;
    logic [15:0]   w_offset;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    crcfc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (s_axis_tdata),
        .o_crc  (w_crc_fed)
    );

    assign w_crc_pos = CW'(crcfc_pkg::HDR_BYTES) + {1'b0, r_length};
    assign w_offset  = r_count[15:0] - 16'(crcfc_pkg::HDR_BYTES);

    // next frame state for the current byte
    always_comb begin
        n_crc     = r_crc;
        n_version = r_version;
        n_type    = r_type;
        n_seq     = r_seq;
        n_length  = r_length;
        n_crc_rx  = r_crc_rx;
        w_forward = 1'b0;
        if (r_count < CW'(crcfc_pkg::HDR_BYTES)) begin
            n_crc = w_crc_fed;
            unique case (r_count[2:0])
                3'd0:    n_version = s_axis_tdata;
                3'd1:    n_type = s_axis_tdata;
                3'd2:    n_seq = {r_seq[15:8], s_axis_tdata};
                3'd3:    n_seq = {s_axis_tdata, r_seq[7:0]};
                3'd4:    n_length = {r_length[15:8], s_axis_tdata};
                default: n_length = {s_axis_tdata, r_length[7:0]};
            endcase
        end else if (r_count < crcfc_pkg::COUNT_MAX) begin
            if (r_count < w_crc_pos) begin
                n_crc     = w_crc_fed;
                w_forward = 1'b1;
            end else if (r_count == w_crc_pos) begin
                n_crc_rx = {r_crc_rx[15:8], s_axis_tdata};
            end else if (r_count == w_crc_pos + CW'(1)) begin
                n_crc_rx = {s_axis_tdata, r_crc_rx[7:0]};
            end
        end
        n_count = (r_count < crcfc_pkg::COUNT_MAX) ? r_count + CW'(1) : r_count;
    end

    // end-of-frame status in priority order
    always_comb begin
        priority if (n_count < CW'(crcfc_pkg::OVERHEAD_BYTES)) begin
            w_status = crcfc_pkg::STATUS_SHORT;
        end else if (n_version != r_exp_version) begin
            w_status = crcfc_pkg::STATUS_VERSION;
        end else if ({1'b0, n_length} + CW'(crcfc_pkg::OVERHEAD_BYTES) != n_count) begin
            w_status = crcfc_pkg::STATUS_SHORT;
        end else if (n_crc_rx != n_crc) begin
            w_status = crcfc_pkg::STATUS_CRC;
        end else begin
            w_status = crcfc_pkg::STATUS_OK;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= crcfc_pkg::VERSION_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exp_version <= i_cfg_data;
        end
    end

    // frame state, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_in_acc && s_axis_tlast)) begin
            r_crc     <= crcfc_pkg::CRC_INIT;
            r_count   <= '0;
            r_version <= '0;
            r_type    <= '0;
            r_seq     <= '0;
            r_length  <= '0;
            r_crc_rx  <= '0;
        end else if (w_in_acc) begin
            r_crc     <= n_crc;
            r_count   <= n_count;
            r_version <= n_version;
            r_type    <= n_type;
            r_seq     <= n_seq;
            r_length  <= n_length;
            r_crc_rx  <= n_crc_rx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= s_axis_tlast || w_forward;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (s_axis_tlast) begin
                r_out_kind <= crcfc_pkg::KIND_STATUS;
                if (w_status == crcfc_pkg::STATUS_OK) begin
                    r_out_data <= {6'd0, n_length, n_seq, n_type, w_status, 16'd0, 8'd0};
                end else begin
                    r_out_data <= {6'd0, 16'd0, 16'd0, 8'd0, w_status, 16'd0, 8'd0};
                end
            end else begin
                r_out_kind <= crcfc_pkg::KIND_PAYLOAD;
                r_out_data <= {6'd0, 16'd0, 16'd0, 8'd0, 2'd0, w_offset, s_axis_tdata};
            end
        end
    end

endmodule

// ----- bench/tb_crc_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc_frame_checker: self-checking bench for the crc frame checker
// Streams byte frames into the checker and tracks the header, payload and
// crc-16 of each frame in a bench-side copy of the checker state. Every
// forwarded payload byte and every end-of-frame status is compared field by
// field in arrival order. The expected version register is rewritten between
// phases, and the idle pattern of both stream sides changes in phases 1 and 2.
// Frames are mostly well formed with random content, plus corrupted, cut,
// overlong and noise sequences.
// ----------------------------------------------------------------------------
module tb_crc_frame_checker;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_stream_item;

    typedef struct {
        logic        kind;
        logic [7:0]  pbyte;
        logic [15:0] poffset;
        logic [1:0]  status;
        logic [7:0]  ftype;
        logic [15:0] fseq;
        logic [15:0] plen;
    } t_frame_output;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [7:0]  i_cfg_data    = 8'h00;
    logic        o_cfg_ready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;    // in_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;            // [7:0] payload_byte, [23:8] payload_offset,
                                          // [25:24] frame_status, [33:26] frame_type,
                                          // [49:34] frame_seq, [65:50] payload_len
    logic        m_axis_tuser;            // out_kind

    // bench copy of the checker state
    logic [7:0]  version_reg;
    logic [15:0] crc_acc;
    logic [16:0] byte_cnt;
    logic [7:0]  ver_seen;
    logic [7:0]  type_seen;
    logic [15:0] seq_seen;
    logic [15:0] len_seen;
    logic [15:0] crc_rx;

    t_stream_item  bytes_to_send[$];
    t_frame_output outputs_due[$];
    t_stream_item  drv_item;
    t_frame_output due_item;

    int send_idle    = 10;
    int recv_idle    = 61;
    int fail_count   = 0;
    int queued_count = 0;
    int cycle_count  = 0;

    crc_frame_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[crc_frame_checker] ERROR");
            $finish;
        end
    end

    // bytewise crc-16 ccitt-false update, msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = ((c & crcfc_pkg::CRC_MSB) != 16'h0) ? ((c << 1) ^ crcfc_pkg::CRC_POLY)
                                                     : (c << 1);
        return c;
    endfunction

    task automatic clear_frame_state();
        crc_acc   = crcfc_pkg::CRC_INIT;
        byte_cnt  = '0;
        ver_seen  = '0;
        type_seen = '0;
        seq_seen  = '0;
        len_seen  = '0;
        crc_rx    = '0;
    endtask

    // track one accepted byte and queue the output it causes
    task automatic frame_check_byte(input logic [7:0] b, input logic last);
        int unsigned   pos;
        int unsigned   crc_pos;
        int unsigned   total;
        bit            fwd;
        t_frame_output o;
        pos     = 32'(byte_cnt);
        crc_pos = crcfc_pkg::HDR_BYTES + int'(len_seen);
        fwd     = 1'b0;
        o       = '{crcfc_pkg::KIND_PAYLOAD, 8'h00, 16'h0000, crcfc_pkg::STATUS_OK,
                    8'h00, 16'h0000, 16'h0000};

        if (pos < crcfc_pkg::HDR_BYTES) begin
            crc_acc = crc16_step(crc_acc, b);
            case (pos)
                0: ver_seen  = b;
                1: type_seen = b;
                2: seq_seen[7:0]  = b;
                3: seq_seen[15:8] = b;
                4: len_seen[7:0]  = b;
                default: len_seen[15:8] = b;
            endcase
        end else if (pos < crcfc_pkg::COUNT_MAX) begin
            if (pos < crc_pos) begin
                crc_acc = crc16_step(crc_acc, b);
                fwd     = 1'b1;
            end else if (pos == crc_pos) begin
                crc_rx[7:0] = b;
            end else if (pos == crc_pos + 1) begin
                crc_rx[15:8] = b;
            end
        end

        if (byte_cnt < crcfc_pkg::COUNT_MAX)
            byte_cnt = byte_cnt + 1'b1;

        if (!last) begin
            if (fwd) begin
                o.pbyte   = b;
                o.poffset = 16'(pos - crcfc_pkg::HDR_BYTES);
                outputs_due.push_back(o);
            end
        end else begin
            total  = 32'(byte_cnt);
            o.kind = crcfc_pkg::KIND_STATUS;
            if (total < crcfc_pkg::OVERHEAD_BYTES)
                o.status = crcfc_pkg::STATUS_SHORT;
            else if (ver_seen != version_reg)
                o.status = crcfc_pkg::STATUS_VERSION;
            else if (int'(len_seen) + crcfc_pkg::OVERHEAD_BYTES != total)
                o.status = crcfc_pkg::STATUS_SHORT;
            else if (crc_rx != crc_acc)
                o.status = crcfc_pkg::STATUS_CRC;
            else
                o.status = crcfc_pkg::STATUS_OK;
            if (o.status == crcfc_pkg::STATUS_OK) begin
                o.ftype = type_seen;
                o.fseq  = seq_seen;
                o.plen  = len_seen;
            end
            outputs_due.push_back(o);
            clear_frame_state();
        end
    endtask

    // stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                frame_check_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    drv_item = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drv_item.data;
                    s_axis_tlast  <= drv_item.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outputs_due.size() == 0) begin
                    $error("output item with none due: tdata %0h, tuser %0b",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    due_item = outputs_due.pop_front();
                    check_field("out_kind",       16'(due_item.kind),
                                16'(m_axis_tuser));
                    check_field("payload_byte",   16'(due_item.pbyte),
                                16'(m_axis_tdata[7:0]));
                    check_field("payload_offset", due_item.poffset, m_axis_tdata[23:8]);
                    check_field("frame_status",   16'(due_item.status),
                                16'(m_axis_tdata[25:24]));
                    check_field("frame_type",     16'(due_item.ftype),
                                16'(m_axis_tdata[33:26]));
                    check_field("frame_seq",      due_item.fseq,    m_axis_tdata[49:34]);
                    check_field("payload_len",    due_item.plen,    m_axis_tdata[65:50]);
                    check_field("tdata padding",  16'h0000,
                                16'(m_axis_tdata[71:66]));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // wait until every queued byte is taken and every due output has come;
    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (bytes_to_send.size() != 0 || s_axis_tvalid || outputs_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [7:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        version_reg = v;
        @(posedge i_clk);
    endtask

    // build a frame: header, body, crc, trailing bytes; optionally cut short
    task automatic queue_frame(input logic [7:0] ver, input logic [7:0] ftype,
                               input logic [15:0] seq, input logic [15:0] len,
                               input int body_len, input bit bad_crc, input int extra,
                               input int keep, input int pause_at);
        logic [7:0]   fb[$];
        logic [15:0]  crc;
        t_stream_item it;
        int           n;
        fb.push_back(ver);
        fb.push_back(ftype);
        fb.push_back(seq[7:0]);
        fb.push_back(seq[15:8]);
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        for (int i = 0; i < body_len; i++)
            fb.push_back(8'($urandom));
        crc = crcfc_pkg::CRC_INIT;
        foreach (fb[i])
            crc = crc16_step(crc, fb[i]);
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        for (int i = 0; i < extra; i++)
            fb.push_back(8'($urandom));
        n = (keep > 0 && keep < fb.size()) ? keep : fb.size();
        for (int i = 0; i < n; i++) begin
            if (i == pause_at)
                wait_drained();
            it.data = fb[i];
            it.last = (i == n - 1);
            bytes_to_send.push_back(it);
        end
        queued_count += n;
    endtask

    // mostly good frames, some corrupted, cut or overlong, some raw noise
    task automatic queue_random_frame();
        int          pick;
        logic [7:0]  ver;
        logic [15:0] len;
        int          body;
        t_stream_item it;
        pick = $urandom_range(0, 99);
        ver  = version_reg;
        len  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 300))
                                           : 16'($urandom_range(0, 12));
        body = int'(len);
        if (pick < 60) begin
            queue_frame(ver, 8'($urandom), 16'($urandom), len, body, 1'b0, 0, 0, -1);
        end else if (pick < 68) begin
            queue_frame(ver, 8'($urandom), 16'($urandom), len, body, 1'b1, 0, 0, -1);
        end else if (pick < 74) begin
            ver = ver ^ (8'h01 << $urandom_range(0, 7));
            queue_frame(ver, 8'($urandom), 16'($urandom), len, body, 1'b0, 0, 0, -1);
        end else if (pick < 80) begin
            body = ($urandom_range(0, 1) == 0) ? body + $urandom_range(1, 3)
                                               : ((body > 0) ? body - 1 : body + 1);
            queue_frame(ver, 8'($urandom), 16'($urandom), len, body, 1'b0, 0, 0, -1);
        end else if (pick < 85) begin
            queue_frame(ver, 8'($urandom), 16'($urandom), len, body, 1'b0,
                        $urandom_range(1, 4), 0, -1);
        end else if (pick < 92) begin
            queue_frame(ver, 8'($urandom), 16'($urandom), len, body, 1'b0, 0,
                        $urandom_range(1, body + 7), -1);
        end else begin
            repeat ($urandom_range(1, 10)) begin
                it.data = 8'($urandom);
                it.last = ($urandom_range(0, 3) == 0);
                bytes_to_send.push_back(it);
                queued_count++;
            end
        end
    endtask

    // main sequence
    initial begin
        version_reg = crcfc_pkg::VERSION_RESET;
        clear_frame_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 0: reset version, sender idles lightly, receiver heavily
        queued_count = 0;
        // single byte frame
        queue_frame(8'h00, 8'h00, 16'h0000, 16'h0000, 0, 1'b0, 0, 1, -1);
        // good frame, one payload byte, extreme header values
        queue_frame(8'h01, 8'hFF, 16'hFFFF, 16'h0001, 1, 1'b0, 0, 0, -1);
        // bad crc, empty payload
        queue_frame(8'h01, 8'h00, 16'h0000, 16'h0000, 0, 1'b1, 0, 0, -1);
        // final byte lands in the payload
        queue_frame(8'h01, 8'h3C, 16'h1234, 16'h0001, 1, 1'b0, 0, 7, -1);
        while (queued_count < 650)
            queue_random_frame();

        // phase 1: idling swapped, version 0
        write_version(8'h00);
        send_idle = 61;
        recv_idle = 10;
        queued_count = 0;
        // sender holds off mid-payload until all due outputs have come
        queue_frame(version_reg, 8'($urandom), 16'($urandom), 16'h0005, 5, 1'b0, 0, 0, 8);
        while (queued_count < 650)
            queue_random_frame();

        // phase 2: no idling, version all ones
        write_version(8'hFF);
        send_idle = 0;
        recv_idle = 0;
        queued_count = 0;
        while (queued_count < 650)
            queue_random_frame();

        // phase 3: mid version
        write_version(8'($urandom_range(2, 254)));
        queued_count = 0;
        while (queued_count < 100)
            queue_random_frame();

        wait_drained();
        if (fail_count == 0)
            $display("[crc_frame_checker] OK");
        else
            $display("[crc_frame_checker] ERROR");
        $finish;
    end

endmodule
